/* design/sst_pkg.sv */
package sst_pkg;

	localparam int KEY_W = 64;
	localparam int SCORE_W = 32;
	localparam int RANK_W = 4;
	localparam int TOTAL_W = 5;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_READ   = 2'd2,
		ACT_IGNORE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		STS_INSERTED   = 3'd0,
		STS_DUPLICATE  = 3'd1,
		STS_FULL       = 3'd2,
		STS_DELETED    = 3'd3,
		STS_NOT_FOUND  = 3'd4,
		STS_READ_OK    = 3'd5,
		STS_RANK_EMPTY = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_INS_SHIFT,
		ST_PLACE,
		ST_DEL_SHIFT,
		ST_READ_WAIT,
		ST_FIN
	} state_t;

	typedef struct packed {
		action_t                    action;
		logic [KEY_W-1:0]           entry_key;
		logic signed [SCORE_W-1:0]  entry_score;
		logic [RANK_W-1:0]          read_rank;
	} req_t;

	typedef struct packed {
		status_t                    status;
		logic [KEY_W-1:0]           out_key;
		logic signed [SCORE_W-1:0]  out_score;
		logic [TOTAL_W-1:0]         entry_total;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]           key;
		logic signed [SCORE_W-1:0]  score;
	} entry_t;

endpackage

/* design/sorted_score_table_top.sv */
// an insert scans the keys, shifts lower-scored entries down one per cycle, then places the entry;
// a delete scans the keys, then moves each later entry up; a read waits for the memory read;
// a full insert, an empty delete, a bad read rank or an ignore goes straight to the response;
// one transaction in flight: the next is accepted at the edge after rsp_valid rises if not stalled
// reset clears the entry count and the control state; memory contents are not cleared
module sorted_score_table_top #(
	parameter int CAPACITY = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sst_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sst_pkg::rsp_t rsp
);
	import sst_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int RW = (CNT_W > RANK_W) ? CNT_W : RANK_W;

	state_t state_q, state_d;
	req_t cur_q;
	logic [IDX_W-1:0] ptr_q, ptr_d;
	logic [CNT_W-1:0] count_q;
	status_t res_status_q, res_status;
	logic [KEY_W-1:0] res_key_q;
	logic signed [SCORE_W-1:0] res_score_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic [IDX_W-1:0] rd_addr, wr_addr;
	logic wr_en;
	entry_t wr_data, rd_data, new_entry;
	logic res_load, res_from_mem, cnt_inc, cnt_dec, out_load;

	logic acc, hit, last, above, full, empty, rank_ok, out_free;
	logic [CNT_W-1:0] ptr_nx;
	logic [RW-1:0] rank_ext;

	assign acc = req_valid && (state_q == ST_IDLE);
	assign req_stall = (state_q != ST_IDLE);
	assign ptr_nx = CNT_W'(ptr_q) + CNT_W'(1);
	assign hit = (rd_data.key == cur_q.entry_key);
	assign last = (ptr_nx == count_q);
	assign above = (cur_q.entry_score > rd_data.score);
	assign full = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);
	assign rank_ext = RW'(req.read_rank);
	assign rank_ok = (rank_ext < RW'(count_q));
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign new_entry = '{key: cur_q.entry_key, score: cur_q.entry_score};

	sst_store #(.DEPTH(CAPACITY)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					unique case (req.action)
						ACT_INSERT: begin
							priority if (full) state_d = ST_FIN;
							else if (empty) state_d = ST_PLACE;
							else state_d = ST_SCAN;
						end
						ACT_DELETE: state_d = empty ? ST_FIN : ST_SCAN;
						ACT_READ:   state_d = rank_ok ? ST_READ_WAIT : ST_FIN;
						ACT_IGNORE: state_d = ST_FIN;
						default:    state_d = ST_FIN;
					endcase
				end
			end
			ST_SCAN: begin
				priority if (hit) begin
					if (cur_q.action == ACT_INSERT || last) state_d = ST_FIN;
					else state_d = ST_DEL_SHIFT;
				end else if (last) begin
					state_d = (cur_q.action == ACT_INSERT) ? ST_INS_SHIFT : ST_FIN;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_INS_SHIFT: begin
				priority if (!above) state_d = ST_FIN;
				else if (ptr_q == '0) state_d = ST_PLACE;
				else state_d = ST_INS_SHIFT;
			end
			ST_PLACE:     state_d = ST_FIN;
			ST_DEL_SHIFT: if (last) state_d = ST_FIN;
			ST_READ_WAIT: state_d = ST_FIN;
			ST_FIN:       if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		rd_addr = ptr_q;
		ptr_d = ptr_q;
		wr_en = 1'b0;
		wr_addr = ptr_q;
		wr_data = new_entry;
		res_load = 1'b0;
		res_from_mem = 1'b0;
		res_status = STS_RANK_EMPTY;
		cnt_inc = 1'b0;
		cnt_dec = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				rd_addr = '0;
				ptr_d = '0;
				if (req_valid) begin
					unique case (req.action)
						ACT_INSERT: begin
							res_load = full;
							res_status = STS_FULL;
						end
						ACT_DELETE: begin
							res_load = empty;
							res_status = STS_NOT_FOUND;
						end
						ACT_READ: begin
							rd_addr = rank_ext[IDX_W-1:0];
							res_load = !rank_ok;
							res_status = STS_RANK_EMPTY;
						end
						ACT_IGNORE: begin
							res_load = 1'b1;
							res_status = STS_RANK_EMPTY;
						end
						default: begin
							res_load = 1'b1;
							res_status = STS_RANK_EMPTY;
						end
					endcase
				end
			end
			ST_SCAN: begin
				priority if (hit) begin
					if (cur_q.action == ACT_INSERT) begin
						res_load = 1'b1;
						res_status = STS_DUPLICATE;
					end else if (last) begin
						cnt_dec = 1'b1;
						res_load = 1'b1;
						res_status = STS_DELETED;
					end else begin
						rd_addr = ptr_q + IDX_W'(1);
						ptr_d = ptr_q + IDX_W'(1);
					end
				end else if (last) begin
					if (cur_q.action != ACT_INSERT) begin
						res_load = 1'b1;
						res_status = STS_NOT_FOUND;
					end
				end else begin
					rd_addr = ptr_q + IDX_W'(1);
					ptr_d = ptr_q + IDX_W'(1);
				end
			end
			ST_INS_SHIFT: begin
				wr_en = 1'b1;
				wr_addr = ptr_q + IDX_W'(1);
				if (above) begin
					wr_data = rd_data;
					if (ptr_q != '0) begin
						rd_addr = ptr_q - IDX_W'(1);
						ptr_d = ptr_q - IDX_W'(1);
					end
				end else begin
					cnt_inc = 1'b1;
					res_load = 1'b1;
					res_status = STS_INSERTED;
				end
			end
			ST_PLACE: begin
				wr_en = 1'b1;
				cnt_inc = 1'b1;
				res_load = 1'b1;
				res_status = STS_INSERTED;
			end
			ST_DEL_SHIFT: begin
				wr_en = 1'b1;
				wr_addr = ptr_q - IDX_W'(1);
				wr_data = rd_data;
				if (last) begin
					cnt_dec = 1'b1;
					res_load = 1'b1;
					res_status = STS_DELETED;
				end else begin
					rd_addr = ptr_q + IDX_W'(1);
					ptr_d = ptr_q + IDX_W'(1);
				end
			end
			ST_READ_WAIT: begin
				res_load = 1'b1;
				res_from_mem = 1'b1;
				res_status = STS_READ_OK;
			end
			ST_FIN: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		if (acc) begin
			cur_q <= req;
		end
		if (res_load) begin
			res_status_q <= res_status;
			res_key_q <= res_from_mem ? rd_data.key : '0;
			res_score_q <= res_from_mem ? rd_data.score : '0;
		end
		if (out_load) begin
			rsp_q.status <= res_status_q;
			rsp_q.out_key <= res_key_q;
			rsp_q.out_score <= res_score_q;
			rsp_q.entry_total <= TOTAL_W'(count_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INS_SHIFT) |-> (!full && ptr_nx <= count_q))
		else $error("insert shift outside the table");

	a_del_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DEL_SHIFT) |-> (ptr_q != '0 && ptr_nx <= count_q))
		else $error("delete move outside the table");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_READ_WAIT || state_q == ST_FIN)
			|=> $stable(count_q))
		else $error("entry count changed outside an update");

endmodule

/* design/sst_store.sv */
module sst_store #(
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  sst_pkg::entry_t wr_data,
	input  logic [AW-1:0]   rd_addr,
	output sst_pkg::entry_t rd_data
);
	import sst_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule
